// ===== rtl/tvpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvpc_pkg
// Types, codes and defaults shared by the track/vertex pileup classifier.
// ----------------------------------------------------------------------------
package tvpc_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int MAX_TRACKS_DEF   = 256;

   localparam logic [11:0] ANGLE_TOL_RST = 12'd41;
   localparam logic [9:0]  PT_TOL_RST    = 10'd10;
   localparam logic [15:0] Z_TOL_RST     = 16'd10;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CSR_ANGLE_TOL = 2'd0,
      CSR_PT_TOL    = 2'd1,
      CSR_Z_TOL     = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      FN_CLEAR     = 3'd0,
      FN_LOAD_VTX  = 3'd1,
      FN_LOAD_TRK  = 3'd2,
      FN_SIG_TRK   = 3'd3,
      FN_CANDIDATE = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRK_RD,
      ST_TRK_CMP,
      ST_VTX_RD,
      ST_VTX_CMP,
      ST_SEL_RD,
      ST_SEL_LATCH,
      ST_MARK_RD,
      ST_MARK_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] track_eta;
      logic [15:0] track_phi;
      logic [15:0] track_pt;
      logic [15:0] z_value;
   } req_type;

   typedef struct packed {
      logic       vertex_found;
      logic [4:0] vertex_index;
      logic       matched_by_track;
      logic       is_signal;
      logic       table_full;
   } rsp_type;

endpackage

// ===== rtl/tvpc_if.sv =====
// ----------------------------------------------------------------------------
// tvpc_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface tvpc_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/track_vertex_pileup_classifier.sv =====
// ----------------------------------------------------------------------------
// track_vertex_pileup_classifier
// Track-to-vertex association and pileup classification, sequenced scans.
// ----------------------------------------------------------------------------
// A query scans the stored tracks until the first kinematic match, then if none
// matched scans the vertices for the nearest z, and a candidate query scans the
// signal marks of the vertices; each table has a single read port and the one
// compare path is shared. The block takes no beat while busy; the result beat
// is held until taken. Tables hold no contents after reset, only counts, so no
// clearing pass is needed.
module track_vertex_pileup_classifier #(
   parameter int MAX_VERTICES = tvpc_pkg::MAX_VERTICES_DEF,
   parameter int MAX_TRACKS   = tvpc_pkg::MAX_TRACKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tvpc_if.sink                            req,
   tvpc_if.source                          rsp,
   input  logic                            csr_wr_en,
   input  logic [tvpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tvpc_pkg::CSR_DATA_W-1:0] csr_data
);
   import tvpc_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int TW = $clog2(MAX_TRACKS);

   state_type state_ff, state_in;

   logic [11:0] ang_tol_ff;
   logic [9:0]  pt_tol_ff;
   logic [15:0] z_tol_ff;

   req_type     q_ff;
   logic [VW:0] vcnt_ff;
   logic [TW:0] tcnt_ff;
   logic [MAX_VERTICES-1:0] marks_ff;

   logic [TW:0] ti_ff, ti_in;
   logic [VW:0] vi_ff, vi_in;
   logic [VW-1:0] sel_ff, sel_in;
   logic        found_ff, found_in, bytrk_ff, bytrk_in;
   logic [16:0] best_ff, best_in;
   logic signed [15:0] selz_ff, selz_in;
   logic        sig_ff, sig_in, full_ff, full_in;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   // memory ports
   logic            vz_we, tr_we;
   logic [VW-1:0]   vz_addr;
   logic [TW-1:0]   tr_addr;
   logic [15:0]     vz_rd, eta_rd, phi_rd, pt_rd;
   logic [VW-1:0]   own_rd;

   tvpc_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_vz (
      .clock, .wr_en(vz_we), .addr(vz_addr), .wr_data(q_ff.z_value), .rd_data(vz_rd));
   tvpc_ram #(.WIDTH(VW), .DEPTH(MAX_TRACKS)) u_own (
      .clock, .wr_en(tr_we), .addr(tr_addr), .wr_data(VW'(vcnt_ff - 1'b1)),
      .rd_data(own_rd));
   tvpc_ram #(.WIDTH(16), .DEPTH(MAX_TRACKS)) u_eta (
      .clock, .wr_en(tr_we), .addr(tr_addr), .wr_data(q_ff.track_eta), .rd_data(eta_rd));
   tvpc_ram #(.WIDTH(16), .DEPTH(MAX_TRACKS)) u_phi (
      .clock, .wr_en(tr_we), .addr(tr_addr), .wr_data(q_ff.track_phi), .rd_data(phi_rd));
   tvpc_ram #(.WIDTH(16), .DEPTH(MAX_TRACKS)) u_pt (
      .clock, .wr_en(tr_we), .addr(tr_addr), .wr_data(q_ff.track_pt), .rd_data(pt_rd));

   logic accept;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req.valid && req.ready;

   logic is_query;
   assign is_query = (q_ff.func == FN_SIG_TRK) || (q_ff.func == FN_CANDIDATE);

   // shared compare path
   logic [16:0] d_eta, d_phi, d_z;
   logic [16:0] dpt_u;
   logic [26:0] dpt_sc;
   logic [25:0] pt_lim;
   logic        kin_hit;
   logic signed [15:0] z_ref;

   function automatic logic [16:0] absdiff(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [16:0] d;
      d = 17'(a) - 17'(b);
      return d[16] ? 17'(-d) : 17'(d);
   endfunction

   assign z_ref = (state_ff == ST_MARK_CMP) ? selz_ff : $signed(q_ff.z_value);
   assign d_eta = absdiff($signed(eta_rd), $signed(q_ff.track_eta));
   assign d_phi = absdiff($signed(phi_rd), $signed(q_ff.track_phi));
   assign d_z   = absdiff($signed(vz_rd), z_ref);
   assign dpt_u  = (pt_rd >= q_ff.track_pt) ? 17'(pt_rd - q_ff.track_pt)
                                            : 17'(q_ff.track_pt - pt_rd);
   assign dpt_sc = {dpt_u, 10'd0};
   assign pt_lim = pt_tol_ff * q_ff.track_pt;
   assign kin_hit = (d_eta < 17'(ang_tol_ff)) && (d_phi < 17'(ang_tol_ff))
                    && (dpt_sc < 27'(pt_lim));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_TRK_RD;
         ST_TRK_RD: begin
            if (!is_query) state_in = ST_DONE;
            else if (ti_ff < tcnt_ff) state_in = ST_TRK_CMP;
            else state_in = ST_VTX_RD;
         end
         ST_TRK_CMP:   state_in = kin_hit ? ST_SEL_RD : ST_TRK_RD;
         ST_VTX_RD:    state_in = (vi_ff < vcnt_ff) ? ST_VTX_CMP : ST_SEL_RD;
         ST_VTX_CMP:   state_in = ST_VTX_RD;
         ST_SEL_RD: begin
            if (!found_ff || q_ff.func == FN_SIG_TRK) state_in = ST_DONE;
            else state_in = ST_SEL_LATCH;
         end
         ST_SEL_LATCH: state_in = ST_MARK_RD;
         ST_MARK_RD:   state_in = (vi_ff < vcnt_ff && !sig_ff) ? ST_MARK_CMP : ST_DONE;
         ST_MARK_CMP:  state_in = ST_MARK_RD;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      ti_in = ti_ff; vi_in = vi_ff; sel_in = sel_ff; found_in = found_ff;
      bytrk_in = bytrk_ff; best_in = best_ff; selz_in = selz_ff;
      sig_in = sig_ff; full_in = full_ff;
      vz_we = 1'b0; tr_we = 1'b0;
      vz_addr = vi_ff[VW-1:0];
      tr_addr = ti_ff[TW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            ti_in = '0; vi_in = '0; found_in = 1'b0; bytrk_in = 1'b0;
            sig_in = 1'b0; full_in = 1'b0; best_in = '0;
         end
         ST_TRK_RD: begin
            if (q_ff.func == FN_LOAD_VTX) begin
               if (vcnt_ff < (VW+1)'(MAX_VERTICES)) begin
                  vz_we = 1'b1; vz_addr = vcnt_ff[VW-1:0];
               end else full_in = 1'b1;
            end else if (q_ff.func == FN_LOAD_TRK && vcnt_ff != '0) begin
               if (tcnt_ff < (TW+1)'(MAX_TRACKS)) begin
                  tr_we = 1'b1; tr_addr = tcnt_ff[TW-1:0];
               end else full_in = 1'b1;
            end
         end
         ST_TRK_CMP: begin
            if (kin_hit) begin
               found_in = 1'b1; bytrk_in = 1'b1; sel_in = own_rd;
            end
            ti_in = ti_ff + 1'b1;
         end
         ST_VTX_CMP: begin
            if (!found_ff || d_z < best_ff) begin
               found_in = 1'b1; best_in = d_z; sel_in = vi_ff[VW-1:0];
            end
            vi_in = vi_ff + 1'b1;
         end
         ST_SEL_RD: begin
            vz_addr = sel_ff;
            vi_in = '0;
            sig_in = found_ff && (q_ff.func == FN_SIG_TRK);
         end
         ST_SEL_LATCH: selz_in = $signed(vz_rd);
         ST_MARK_CMP: begin
            if (marks_ff[vi_ff[VW-1:0]] &&
                (vi_ff[VW-1:0] == sel_ff || d_z < 17'(z_tol_ff))) sig_in = 1'b1;
            vi_in = vi_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ang_tol_ff   <= ANGLE_TOL_RST;
         pt_tol_ff    <= PT_TOL_RST;
         z_tol_ff     <= Z_TOL_RST;
         vcnt_ff      <= '0;
         tcnt_ff      <= '0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ANGLE_TOL: ang_tol_ff <= csr_data[11:0];
               CSR_PT_TOL:    pt_tol_ff  <= csr_data[9:0];
               CSR_Z_TOL:     z_tol_ff   <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_TRK_RD) begin
            if (q_ff.func == FN_CLEAR) begin
               vcnt_ff <= '0; tcnt_ff <= '0; marks_ff <= '0;
            end
            if (vz_we) begin
               vcnt_ff <= vcnt_ff + 1'b1;
               marks_ff[vcnt_ff[VW-1:0]] <= 1'b0;
            end
            if (tr_we) tcnt_ff <= tcnt_ff + 1'b1;
         end
         if (state_ff == ST_SEL_RD && found_ff && q_ff.func == FN_SIG_TRK)
            marks_ff[sel_ff] <= 1'b1;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff <= req.data;
      ti_ff <= ti_in; vi_ff <= vi_in; sel_ff <= sel_in; found_ff <= found_in;
      bytrk_ff <= bytrk_in; best_ff <= best_in; selz_ff <= selz_in;
      sig_ff <= sig_in; full_ff <= full_in;
      if (state_ff == ST_DONE) begin
         rsp_ff.vertex_found     <= found_ff;
         rsp_ff.vertex_index     <= found_ff ? 5'(sel_ff) : 5'd0;
         rsp_ff.matched_by_track <= found_ff & bytrk_ff;
         rsp_ff.is_signal        <= sig_ff;
         rsp_ff.table_full       <= full_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // a new beat is never taken while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("accept while result pending");
   // vertex count never exceeds capacity
   a_vcnt_cap: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= (VW+1)'(MAX_VERTICES)) else $error("vertex count overflow");
   // result is raised in the cycle after the done step
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff) else $error("result not raised");
endmodule

// ===== rtl/tvpc_ram.sv =====
// ----------------------------------------------------------------------------
// tvpc_ram
// Single-port RAM, one access per cycle (a write also reads the old word), registered read data.
// ----------------------------------------------------------------------------
module tvpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the track/vertex pileup classifier. Drives loads,
// clears and queries over the request channel, predicts every response beat
// in-bench and compares field by field; tolerances are changed between phases.
// ----------------------------------------------------------------------------
module tb;
   import tvpc_pkg::*;

   localparam int NV        = MAX_VERTICES_DEF;
   localparam int NT        = MAX_TRACKS_DEF;
   localparam int IDLE_MAX  = 20000;
   localparam int HOLD_LEN  = 3000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   tvpc_if #(.PAYLOAD_TYPE(req_type)) req_if ();
   tvpc_if #(.PAYLOAD_TYPE(rsp_type)) rsp_if ();

   track_vertex_pileup_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predicted block state
   logic signed [15:0] vtx_z [NV];
   logic [4:0]         trk_owner [NT];
   logic signed [15:0] trk_eta [NT];
   logic signed [15:0] trk_phi [NT];
   logic [15:0]        trk_pt [NT];
   bit                 sig_mark [NV];
   int                 n_vtx, n_trk;
   logic [11:0]        angle_tol;
   logic [9:0]         pt_tol;
   logic [15:0]        z_tol;

   rsp_type expected_rsp [$];
   int errors = 0, n_req = 0, n_rsp = 0, n_settings = 0;
   int idle_cycles = 0;
   bit hold_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint absdiff(longint a, longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Association and classification of one item; updates predicted state.
   function automatic rsp_type classify(req_type r);
      rsp_type o;
      longint best;
      int v;
      bit hit;
      logic signed [15:0] eta, phi, z;
      eta = r.track_eta;
      phi = r.track_phi;
      z   = r.z_value;
      o   = '0;
      hit = 0;
      v   = 0;
      case (r.func)
         FN_CLEAR: begin
            n_vtx = 0;
            n_trk = 0;
            foreach (sig_mark[i]) sig_mark[i] = 0;
         end
         FN_LOAD_VTX: begin
            if (n_vtx < NV) begin
               vtx_z[n_vtx] = z;
               sig_mark[n_vtx] = 0;
               n_vtx++;
            end else o.table_full = 1'b1;
         end
         FN_LOAD_TRK: begin
            if (n_vtx > 0) begin
               if (n_trk < NT) begin
                  trk_owner[n_trk] = 5'(n_vtx - 1);
                  trk_eta[n_trk] = eta;
                  trk_phi[n_trk] = phi;
                  trk_pt[n_trk]  = r.track_pt;
                  n_trk++;
               end else o.table_full = 1'b1;
            end
         end
         FN_SIG_TRK, FN_CANDIDATE: begin
            for (int i = 0; i < n_trk && !hit; i++) begin
               if (absdiff(trk_eta[i], eta) < longint'(angle_tol) &&
                   absdiff(trk_phi[i], phi) < longint'(angle_tol) &&
                   absdiff(trk_pt[i], r.track_pt) * 1024 <
                      longint'(pt_tol) * longint'(r.track_pt)) begin
                  hit = 1;
                  v = trk_owner[i];
                  o.matched_by_track = 1'b1;
               end
            end
            if (!hit) begin
               for (int i = 0; i < n_vtx; i++) begin
                  if (!hit || absdiff(vtx_z[i], z) < best) begin
                     hit = 1;
                     best = absdiff(vtx_z[i], z);
                     v = i;
                  end
               end
            end
            if (hit) begin
               o.vertex_found = 1'b1;
               o.vertex_index = 5'(v);
               if (r.func == FN_SIG_TRK) begin
                  sig_mark[v] = 1;
                  o.is_signal = 1'b1;
               end else begin
                  for (int m = 0; m < n_vtx; m++)
                     if (sig_mark[m] && (m == v ||
                         absdiff(vtx_z[v], vtx_z[m]) < longint'(z_tol)))
                        o.is_signal = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type mk(logic [2:0] f, logic [15:0] eta, logic [15:0] phi,
                                  logic [15:0] pt, logic [15:0] z);
      req_type r;
      r.func = f;
      r.track_eta = eta;
      r.track_phi = phi;
      r.track_pt = pt;
      r.z_value = z;
      return r;
   endfunction

   task automatic send_beat(req_type r);
      int gap;
      gap = $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      expected_rsp = {expected_rsp, classify(r)};
      n_req++;
   endtask

   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_tolerances(logic [11:0] a, logic [9:0] p, logic [15:0] zt);
      // the last beat is already taken; stop offering it again
      req_if.valid <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ANGLE_TOL;
      csr_data  <= 16'(a);
      @(posedge clock);
      angle_tol = a;
      csr_index <= CSR_PT_TOL;
      csr_data  <= 16'(p);
      @(posedge clock);
      pt_tol = p;
      csr_index <= CSR_Z_TOL;
      csr_data  <= zt;
      @(posedge clock);
      z_tol = zt;
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   // Response side: random back-pressure, with one long hold on request.
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_rsp = 0;
         end else begin
            gap = $urandom_range(0, 13);
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Response checker and stall watchdog
   always @(posedge clock) begin
      rsp_type e, a;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         a = rsp_if.data;
         n_rsp++;
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing expected: %h", a);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (a.vertex_found !== e.vertex_found) begin
               $error("vertex_found exp %0d got %0d", e.vertex_found, a.vertex_found);
               errors++;
            end
            if (a.vertex_index !== e.vertex_index) begin
               $error("vertex_index exp %0d got %0d", e.vertex_index, a.vertex_index);
               errors++;
            end
            if (a.matched_by_track !== e.matched_by_track) begin
               $error("matched_by_track exp %0d got %0d", e.matched_by_track,
                      a.matched_by_track);
               errors++;
            end
            if (a.is_signal !== e.is_signal) begin
               $error("is_signal exp %0d got %0d", e.is_signal, a.is_signal);
               errors++;
            end
            if (a.table_full !== e.table_full) begin
               $error("table_full exp %0d got %0d", e.table_full, a.table_full);
               errors++;
            end
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
         $display("watchdog: no beat for %0d cycles", IDLE_MAX);
         $display("track_vertex_pileup_classifier: mismatch");
         $finish;
      end
   end

   // Extremes of every field, unused codes, track before any vertex.
   task automatic test_fields_and_codes();
      send_beat(mk(FN_LOAD_TRK, 16'h7fff, 16'h8000, 16'hffff, 16'h0000));
      send_beat(mk(FN_CANDIDATE, 16'h0, 16'h0, 16'h0, 16'h0));
      send_beat(mk(FN_SIG_TRK, 16'h0, 16'h0, 16'h0, 16'h0));
      send_beat(mk(FN_LOAD_VTX, 16'hffff, 16'hffff, 16'hffff, 16'h8000));
      send_beat(mk(FN_LOAD_VTX, 16'h0, 16'h0, 16'h0, 16'h7fff));
      send_beat(mk(FN_LOAD_TRK, 16'h8000, 16'h7fff, 16'h0000, 16'h0));
      send_beat(mk(FN_LOAD_TRK, 16'h7fff, 16'h8000, 16'hffff, 16'h0));
      send_beat(mk(FN_LOAD_TRK, 16'h0100, 16'h0200, 16'h0400, 16'h0));
      for (int f = 5; f < 8; f++)
         send_beat(mk(3'(f), 16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_beat(mk(FN_CANDIDATE, 16'h0101, 16'h01fe, 16'h0401, 16'h0));
      send_beat(mk(FN_SIG_TRK, 16'h7fff, 16'h8000, 16'hffff, 16'h0));
      send_beat(mk(FN_CANDIDATE, 16'h0105, 16'h0205, 16'h0400, 16'h0));
      // pt zero never matches kinematically; z zero falls nearest to vertex 1
      send_beat(mk(FN_CANDIDATE, 16'h8000, 16'h7fff, 16'h0000, 16'h0));
      send_beat(mk(FN_CANDIDATE, 16'h1234, 16'h4321, 16'h0040, 16'hffff));
      send_beat(mk(FN_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_beat(mk(FN_CANDIDATE, 16'h0100, 16'h0200, 16'h0400, 16'h0));
   endtask

   // Fill both tables past capacity, then query the full track table.
   task automatic test_capacity();
      send_beat(mk(FN_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0));
      for (int i = 0; i <= NV; i++)
         send_beat(mk(FN_LOAD_VTX, 16'd0, 16'd0, 16'd0, 16'(i * 64 - 1000)));
      for (int i = 0; i <= NT; i++)
         send_beat(mk(FN_LOAD_TRK, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom)));
      send_beat(mk(FN_SIG_TRK, 16'h7777, 16'h7777, 16'h0001, 16'(1000)));
      send_beat(mk(FN_CANDIDATE, 16'h7777, 16'h7777, 16'h0001, 16'(1010)));
      send_beat(mk(FN_CANDIDATE, 16'h7777, 16'h7777, 16'h0001, 16'h8000));
   endtask

   // Well-formed events with random content plus some noise beats.
   task automatic test_random_events(int n_events);
      logic [15:0] e_q [$], p_q [$], t_q [$];
      logic [15:0] z, pt;
      int nv, nq, k, d;
      for (int ev = 0; ev < n_events; ev++) begin
         e_q.delete(); p_q.delete(); t_q.delete();
         send_beat(mk(FN_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom)));
         nv = $urandom_range(1, 6);
         z = 16'($urandom);
         for (int v = 0; v < nv; v++) begin
            z = ($urandom_range(0, 1)) ? 16'($urandom) : z + 16'($urandom_range(0, 40));
            send_beat(mk(FN_LOAD_VTX, 16'($urandom), 16'($urandom), 16'($urandom), z));
            k = $urandom_range(0, 3);
            for (int t = 0; t < k; t++) begin
               e_q = {e_q, 16'($urandom)};
               p_q = {p_q, 16'($urandom)};
               t_q = {t_q, 16'($urandom)};
               send_beat(mk(FN_LOAD_TRK, e_q[$], p_q[$], t_q[$], 16'($urandom)));
            end
         end
         nq = $urandom_range(3, 9);
         for (int q = 0; q < nq; q++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_beat(mk(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom)));
            end else if (e_q.size() > 0 && $urandom_range(0, 9) < 6) begin
               k = $urandom_range(0, e_q.size() - 1);
               d = int'(angle_tol) + 1;
               pt = t_q[k] + 16'($urandom_range(0, 8)) - 16'd4;
               send_beat(mk(($urandom_range(0, 9) < 3) ? FN_SIG_TRK : FN_CANDIDATE,
                            e_q[k] + 16'($urandom_range(0, 2 * d)) - 16'(d),
                            p_q[k] + 16'($urandom_range(0, 2 * d)) - 16'(d),
                            pt, 16'($urandom)));
            end else begin
               send_beat(mk(($urandom_range(0, 9) < 3) ? FN_SIG_TRK : FN_CANDIDATE,
                            16'($urandom), 16'($urandom), 16'($urandom),
                            z + 16'($urandom_range(0, 80)) - 16'd40));
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_ANGLE_TOL;
      csr_data  <= '0;
      hold_rsp = 0;
      angle_tol = ANGLE_TOL_RST;
      pt_tol = PT_TOL_RST;
      z_tol = Z_TOL_RST;
      n_vtx = 0;
      n_trk = 0;
      foreach (sig_mark[i]) sig_mark[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fields_and_codes();
      write_tolerances(12'hfff, 10'h3ff, 16'hffff);
      test_fields_and_codes();
      test_capacity();
      write_tolerances(12'd0, 10'd0, 16'd0);
      test_random_events(4);
      write_tolerances(ANGLE_TOL_RST, PT_TOL_RST, Z_TOL_RST);
      hold_rsp = 1;
      test_random_events(5);
      for (int s = 0; s < 3; s++) begin
         write_tolerances(12'($urandom_range(0, 300)), 10'($urandom),
                          16'($urandom_range(0, 60)));
         test_random_events(4);
      end
      write_tolerances(12'hfff, 10'h3ff, 16'hffff);
      test_random_events(9);

      @(posedge clock);
      req_if.valid <= 1'b0;
      wait_drained();
      repeat (700) @(posedge clock);
      $display("%0d request beats sent, %0d response beats checked", n_req, n_rsp);
      $display("covered %0d tolerance settings, table overflow and a long rsp hold",
               n_settings);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("track_vertex_pileup_classifier: match");
      else
         $display("track_vertex_pileup_classifier: mismatch");
      $finish;
   end

endmodule
